// ===== hw/rtl/hdme_pkg.sv =====
// ----------------------------------------------------------------------------
// hdme_pkg
// Shared constants, codes and control types of the hash dedup and match engine.
// ----------------------------------------------------------------------------
`default_nettype none

package hdme_pkg;

    localparam int SLOT_ADDR_BITS = 12;
    localparam int MAX_ITEMS      = 2048;

    localparam int WORD_BITS   = 32;
    localparam int SLOT_W      = $clog2(MAX_ITEMS + 1);
    localparam int COUNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int KEY_AW      = $clog2(MAX_ITEMS);
    localparam int EFF_W       = $clog2(SLOT_ADDR_BITS + 1);
    localparam int SHIFT_W     = $clog2(WORD_BITS + 1);
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int SLOT_BITS_W = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [WORD_BITS-1:0] HASH_MULT   = 32'd3141592653;
    localparam logic [WORD_BITS-1:0] MISSING_KEY = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_MATCH  = 1'd1;

    localparam logic [SLOT_BITS_W-1:0] SLOT_BITS_RESET = 4'd12;
    localparam logic [WORD_BITS-1:0]   NO_MATCH_RESET  = 32'h8000_0000;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    typedef struct packed {
        logic    load;
        logic    home;
        logic    entry_cap;
        logic    ins_write;
        logic    count_inc;
        logic    count_clr;
        logic    probe_next;
        logic    clr_step;
        logic    out_load;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic func_insert;
        logic slot_empty;
        logic key_eq;
        logic last;
        logic count_full;
        logic clr_last;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/hdme_req_if.sv =====
// ----------------------------------------------------------------------------
// hdme_req_if
// Request channel: operation code and key, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdme_req_if import hdme_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic [FUNC_W-1:0]           func;
    logic signed [WORD_BITS-1:0] key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hdme_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hdme_rsp_if
// Result channel: duplicate flag, match value and status, with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface hdme_rsp_if import hdme_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        is_duplicate;
    logic signed [WORD_BITS-1:0] match_value;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, output is_duplicate, output match_value, output status,
                    input ready);
    modport sink   (input valid, input is_duplicate, input match_value, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hdme_ram.sv =====
// ----------------------------------------------------------------------------
// hdme_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hdme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/hdme_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdme_ctrl
// Controller: sequences the hash, the probe walk, inserts, clears and results.
// ----------------------------------------------------------------------------
`default_nettype none

module hdme_ctrl import hdme_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire logic [FUNC_W-1:0] i_req_func,
    output logic                   o_req_ready,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output t_cmd                   o_cmd,
    input  wire t_sts              i_sts
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MUL,
        S_HOME,
        S_SRD,
        S_SCHK,
        S_KCHK,
        S_CLR,
        S_DONE
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid, n_out_valid;
    t_status r_code, n_code;

    always_comb begin
        o_cmd       = '0;
        o_cmd.code  = r_code;
        n_state     = r_state;
        n_code      = r_code;
        n_out_valid = r_out_valid && !i_rsp_ready;

        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_func)
                        FN_INSERT, FN_LOOKUP: n_state = S_MUL;
                        FN_CLEAR:             n_state = S_CLR;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL: begin
                n_state = S_HOME;
            end
            S_HOME: begin
                o_cmd.home = 1'b1;
                n_state    = S_SRD;
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                o_cmd.entry_cap = 1'b1;
                if (i_sts.slot_empty) begin
                    n_state = S_DONE;
                    if (i_sts.func_insert) begin
                        o_cmd.count_inc = 1'b1;
                        if (i_sts.count_full) begin
                            n_code = ST_FULL;
                        end else begin
                            o_cmd.ins_write = 1'b1;
                            n_code          = ST_INSERTED;
                        end
                    end else begin
                        n_code = ST_NOT_FOUND;
                    end
                end else begin
                    n_state = S_KCHK;
                end
            end
            S_KCHK: begin
                if (i_sts.key_eq) begin
                    n_state = S_DONE;
                    if (i_sts.func_insert) begin
                        o_cmd.count_inc = 1'b1;
                        n_code          = ST_DUPLICATE;
                    end else begin
                        n_code = ST_FOUND;
                    end
                end else if (i_sts.last) begin
                    n_state = S_DONE;
                    if (i_sts.func_insert) begin
                        o_cmd.count_inc = 1'b1;
                        n_code          = ST_FULL;
                    end else begin
                        n_code = ST_NOT_FOUND;
                    end
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_SRD;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.count_clr = 1'b1;
                    n_code          = ST_CLEARED;
                    n_state         = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
            r_code      <= ST_INSERTED;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_code      <= n_code;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/hdme_dpath.sv =====
// ----------------------------------------------------------------------------
// hdme_dpath
// Datapath: hash multiplier, probe registers, slot table, key store and result.
// ----------------------------------------------------------------------------
`default_nettype none

module hdme_dpath import hdme_pkg::*; (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire t_cmd                        i_cmd,
    output t_sts                             o_sts,
    input  wire logic [FUNC_W-1:0]           i_req_func,
    input  wire logic signed [WORD_BITS-1:0] i_req_key,
    input  wire logic                        i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]       i_cfg_data,
    output logic                             o_is_duplicate,
    output logic signed [WORD_BITS-1:0]      o_match_value,
    output logic [STATUS_W-1:0]              o_status
);

    logic [SLOT_BITS_W-1:0]    r_slot_bits;
    logic [WORD_BITS-1:0]      r_no_match;
    logic [FUNC_W-1:0]         r_func;
    logic [WORD_BITS-1:0]      r_key;
    logic [WORD_BITS-1:0]      r_prod;
    logic [SLOT_ADDR_BITS-1:0] r_slot;
    logic [SLOT_ADDR_BITS-1:0] r_cnt;
    logic [SLOT_ADDR_BITS-1:0] r_clr;
    logic [COUNT_W-1:0]        r_count;
    logic [SLOT_W-1:0]         r_entry;
    logic                      r_is_dup;
    logic [WORD_BITS-1:0]      r_match_value;
    t_status                   r_status;

    logic [EFF_W-1:0]          eff;
    logic [SLOT_ADDR_BITS-1:0] mask;
    logic [SHIFT_W-1:0]        sh;
    logic [WORD_BITS-1:0]      home_full;
    logic [SLOT_ADDR_BITS-1:0] home;
    logic                      count_full;

    logic                      slot_we;
    logic [SLOT_ADDR_BITS-1:0] slot_waddr;
    logic [SLOT_W-1:0]         slot_wdata;
    logic [SLOT_W-1:0]         slot_rdata;
    logic [KEY_AW-1:0]         key_raddr;
    logic [WORD_BITS-1:0]      key_rdata;

    always_comb begin
        if (r_slot_bits == '0) begin
            eff = EFF_W'(1);
        end else if (32'(r_slot_bits) > SLOT_ADDR_BITS) begin
            eff = EFF_W'(SLOT_ADDR_BITS);
        end else begin
            eff = EFF_W'(r_slot_bits);
        end
    end

    assign mask      = ~({SLOT_ADDR_BITS{1'b1}} << eff);
    assign sh        = SHIFT_W'(WORD_BITS) - SHIFT_W'(eff);
    assign home_full = r_prod >> sh;
    assign home      = (r_key == MISSING_KEY) ? '0 : home_full[SLOT_ADDR_BITS-1:0];

    assign count_full = (r_count == COUNT_W'(MAX_ITEMS));

    assign slot_we    = i_cmd.clr_step || i_cmd.ins_write;
    assign slot_waddr = i_cmd.clr_step ? r_clr : r_slot;
    assign slot_wdata = i_cmd.clr_step ? '0 : SLOT_W'(r_count + COUNT_W'(1));
    assign key_raddr  = KEY_AW'(slot_rdata - SLOT_W'(1));

    hdme_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (1 << SLOT_ADDR_BITS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (r_slot),
        .o_rdata (slot_rdata)
    );

    hdme_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_write),
        .i_waddr (r_count[KEY_AW-1:0]),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bits <= SLOT_BITS_RESET;
            r_no_match  <= NO_MATCH_RESET;
            r_count     <= '0;
            r_clr       <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLOT_BITS) begin
                    r_slot_bits <= i_cfg_data[SLOT_BITS_W-1:0];
                end else if (i_cfg_idx == CFG_NO_MATCH) begin
                    r_no_match <= i_cfg_data[WORD_BITS-1:0];
                end
            end
            if (i_cmd.count_clr) begin
                r_count <= '0;
            end else if (i_cmd.count_inc && !count_full) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + SLOT_ADDR_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_key * HASH_MULT;
        if (i_cmd.load) begin
            r_func <= i_req_func;
            r_key  <= $unsigned(i_req_key);
        end
        if (i_cmd.home) begin
            r_slot <= home;
            r_cnt  <= '0;
        end else if (i_cmd.probe_next) begin
            r_slot <= (r_slot + SLOT_ADDR_BITS'(1)) & mask;
            r_cnt  <= r_cnt + SLOT_ADDR_BITS'(1);
        end
        if (i_cmd.entry_cap) begin
            r_entry <= slot_rdata;
        end
        if (i_cmd.out_load) begin
            r_is_dup <= (i_cmd.code == ST_DUPLICATE);
            r_status <= i_cmd.code;
            if (i_cmd.code == ST_FOUND) begin
                r_match_value <= WORD_BITS'(r_entry);
            end else if (i_cmd.code == ST_NOT_FOUND) begin
                r_match_value <= r_no_match;
            end else begin
                r_match_value <= '0;
            end
        end
    end

    assign o_sts.func_insert = (r_func == FN_INSERT);
    assign o_sts.slot_empty  = (slot_rdata == '0);
    assign o_sts.key_eq      = (key_rdata == r_key);
    assign o_sts.last        = (r_cnt == mask);
    assign o_sts.count_full  = count_full;
    assign o_sts.clr_last    = (r_clr == {SLOT_ADDR_BITS{1'b1}});

    assign o_is_duplicate = r_is_dup;
    assign o_match_value  = $signed(r_match_value);
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ===== hw/rtl/hash_dedup_and_match_engine.sv =====
// ----------------------------------------------------------------------------
// hash_dedup_and_match_engine
// Open-addressing hash table with linear probing over 32-bit integer keys.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// i_req     in         func, key
// o_rsp     out        is_duplicate, match_value, status
// i_cfg_*   in         write enable, register index, write data
//
// An insert or lookup runs from acceptance through the multiply, home and
// slot read states to a slot check, which ends the probe on an empty slot.
// An occupied slot leads to a key check, which ends it on a matching key or
// the last slot in use. A clear sweeps the slot table one entry a cycle.
// After reset the same sweep runs before the first request is taken.
// A result waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_dedup_and_match_engine import hdme_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hdme_req_if.sink                   i_req,
    hdme_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    hdme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    hdme_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_func     (i_req.func),
        .i_req_key      (i_req.key),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_is_duplicate (o_rsp.is_duplicate),
        .o_match_value  (o_rsp.match_value),
        .o_status       (o_rsp.status)
    );

endmodule

`default_nettype wire
